// File: rtl/tzgc_pkg.sv
// ----------------------------------------------------------------------------
// Tube zone grade and cut package
// Shared constants, codes and types for the tube grade and cut unit.
// ----------------------------------------------------------------------------
package tzgc_pkg;

  localparam int MAX_ZONES = 256;
  localparam int CNT_W     = 9;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes.
  localparam logic CFG_MIN_RUN_LEN   = 1'b0;
  localparam logic CFG_END_CUT_ZONES = 1'b1;

  // Zone grade codes as they arrive on the input.
  localparam logic signed [2:0] ZONE_REJECT = 3'sd0;
  localparam logic signed [2:0] ZONE_SECOND = 3'sd1;
  localparam logic signed [2:0] ZONE_GOOD   = 3'sd2;

  // Tube grade codes of the result.
  localparam logic [1:0] GRADE_REJECT = 2'd0;
  localparam logic [1:0] GRADE_SECOND = 2'd1;
  localparam logic [1:0] GRADE_GOOD   = 2'd2;

  // Operands of one tube decision, held between the two stages.
  typedef struct packed {
    logic             strict;
    logic [1:0]       grade;
    logic [CNT_W-1:0] cut_start;
    logic [CNT_W-1:0] cut_end;
    logic [CNT_W-1:0] zone_count;
    logic [CNT_W-1:0] end_cut;
    logic [CNT_W-1:0] min_len;
  } decision_t;

endpackage

// File: rtl/tube_zone_grade_and_cut_unit.sv
// ----------------------------------------------------------------------------
// Tube zone grade and cut unit
// Tracks usable runs of inspection zones along one tube and, after the last
// zone, gives the tube grade and the two cut positions.
// ----------------------------------------------------------------------------
// Throughput: one zone per cycle; every zone within the tube limit updates
// the run state in the cycle of its transfer. s_tready drops only while both
// stages hold a result. The decision register loads at the transfer of the
// last zone, then the trim check feeds the output register, which raises
// m_tvalid.
// Reset clears both configuration registers, the tube state and the pipeline.
module tube_zone_grade_and_cut_unit
  import tzgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Zone input.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] zone_grade, [7:3] zero
  input  logic                  s_tlast,   // last_zone
  // Decision output.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] tube_grade, [10:2] first_cut,
                                           // [19:11] second_cut, [23:20] zero
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  logic [CNT_W-1:0] min_run_len;
  logic [CNT_W-1:0] end_cut_zones;

  logic [CNT_W-1:0] zone_index, zone_index_next;
  logic [CNT_W-1:0] run_length, run_length_next;
  logic [CNT_W-1:0] run_start, run_start_next;
  logic [CNT_W-1:0] saved_cut_start, saved_cut_start_next;
  logic [CNT_W-1:0] saved_cut_end, saved_cut_end_next;
  logic             run_has_second, run_has_second_next;
  logic             saved_has_second, saved_has_second_next;
  logic             seen_reject, seen_reject_next;
  logic             tube_has_second, tube_has_second_next;

  logic             s1_valid;
  decision_t        s1;
  decision_t        s1_next;

  logic             in_xfer;
  logic             out_free;
  logic signed [2:0] zone_grade;

  assign cfg_ready  = 1'b1;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = !s1_valid || out_free;
  assign in_xfer    = s_tvalid && s_tready;
  assign zone_grade = s_tdata[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_len   <= '0;
      end_cut_zones <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_RUN_LEN:   min_run_len   <= cfg_data;
        CFG_END_CUT_ZONES: end_cut_zones <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run tracking for the zone being transferred.
  always_comb begin
    zone_index_next       = zone_index;
    run_length_next       = run_length;
    run_start_next        = run_start;
    saved_cut_start_next  = saved_cut_start;
    saved_cut_end_next    = saved_cut_end;
    run_has_second_next   = run_has_second;
    saved_has_second_next = saved_has_second;
    seen_reject_next      = seen_reject;
    tube_has_second_next  = tube_has_second;
    // Zones beyond the tube limit are ignored.
    if (zone_index < CNT_W'(MAX_ZONES)) begin
      zone_index_next = zone_index + 1'b1;
      if (zone_grade == ZONE_GOOD) begin
        run_length_next = run_length + 1'b1;
      end else if (zone_grade == ZONE_REJECT) begin
        if (run_length >= min_run_len) begin
          saved_cut_end_next    = zone_index;
          saved_cut_start_next  = zone_index - run_length;
          saved_has_second_next = run_has_second;
        end
        run_length_next     = '0;
        run_start_next      = zone_index + 1'b1;
        run_has_second_next = 1'b0;
        seen_reject_next    = 1'b1;
      end else if (zone_grade == ZONE_SECOND) begin
        run_has_second_next  = 1'b1;
        tube_has_second_next = 1'b1;
        run_length_next      = run_length + 1'b1;
      end
    end
  end

  // First half of the decision, taken from the state after the last zone.
  always_comb begin
    s1_next.strict     = (min_run_len == '0);
    s1_next.zone_count = zone_index_next;
    s1_next.end_cut    = end_cut_zones;
    s1_next.min_len    = min_run_len;
    s1_next.cut_start  = saved_cut_start_next;
    s1_next.cut_end    = saved_cut_end_next;
    if (min_run_len == '0) begin
      s1_next.cut_start = '0;
      s1_next.cut_end   = '0;
      if (seen_reject_next) begin
        s1_next.grade = GRADE_REJECT;
      end else if (tube_has_second_next) begin
        s1_next.grade = GRADE_SECOND;
      end else begin
        s1_next.grade = GRADE_GOOD;
      end
    end else if (run_length_next >= min_run_len) begin
      // The trailing run is long enough and wins.
      s1_next.grade     = run_has_second_next ? GRADE_SECOND : GRADE_GOOD;
      s1_next.cut_start = run_start_next;
      s1_next.cut_end   = '0;
    end else if (saved_cut_start_next == '0 && saved_cut_end_next == '0) begin
      s1_next.grade = GRADE_REJECT;
    end else begin
      s1_next.grade = saved_has_second_next ? GRADE_SECOND : GRADE_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && s_tlast)) begin
      zone_index       <= '0;
      run_length       <= '0;
      run_start        <= '0;
      saved_cut_start  <= '0;
      saved_cut_end    <= '0;
      run_has_second   <= 1'b0;
      saved_has_second <= 1'b0;
      seen_reject      <= 1'b0;
      tube_has_second  <= 1'b0;
    end else if (in_xfer) begin
      zone_index       <= zone_index_next;
      run_length       <= run_length_next;
      run_start        <= run_start_next;
      saved_cut_start  <= saved_cut_start_next;
      saved_cut_end    <= saved_cut_end_next;
      run_has_second   <= run_has_second_next;
      saved_has_second <= saved_has_second_next;
      seen_reject      <= seen_reject_next;
      tube_has_second  <= tube_has_second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= in_xfer && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      s1 <= s1_next;
    end
  end

  // Second half: end-cut trim check and the shift of the first cut.
  logic              trim_on;
  logic [CNT_W-1:0]  cut_end_eff;
  logic signed [11:0] f1, f2, f2_raw, margin;
  logic [1:0]        grade_final;
  logic [CNT_W-1:0]  first_cut;
  logic [CNT_W-1:0]  second_cut;

  always_comb begin
    trim_on     = !s1.strict && (s1.end_cut != '0) && (s1.grade != GRADE_REJECT);
    cut_end_eff = (s1.cut_end == '0) ? s1.zone_count : s1.cut_end;
    f1 = (s1.end_cut > s1.cut_start) ? 12'(s1.end_cut) - 12'(s1.cut_start) : '0;
    f2_raw = 12'(s1.end_cut) + 12'(cut_end_eff) - 12'(s1.zone_count);
    f2 = (f2_raw < 0) ? '0 : f2_raw;
    margin = 12'(cut_end_eff) - 12'(s1.cut_start) - f1 - f2;
    grade_final = s1.grade;
    second_cut  = s1.cut_end;
    if (trim_on) begin
      second_cut = cut_end_eff;
      if (margin < $signed(12'(s1.min_len))) begin
        grade_final = GRADE_REJECT;
      end
    end
    first_cut = (s1.cut_start != '0) ? s1.cut_start + 1'b1 : s1.cut_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {4'b0, second_cut, first_cut, grade_final};
    end
  end

endmodule

// File: rtl/tzgc_checker.sv
// ----------------------------------------------------------------------------
// Tube zone grade and cut checker
// Port-level assertions for the tube grade and cut unit, bound to its top.
// ----------------------------------------------------------------------------
module tzgc_checker
  import tzgc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // No result survives a reset, and the input side is open right after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result pending or input closed after reset");

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The tube grade is never the unused code, and the padding stays zero.
  a_grade_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[23:20] == 4'd0)
    else $error("bad result encoding");

  // With the output empty, the input side never blocks.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind tube_zone_grade_and_cut_unit tzgc_checker u_tzgc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
